@@ rtl/fd_pkg.sv @@
`default_nettype none
package fd_pkg;

    localparam int unsigned AddrW = 5;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_FREEFALL = 2'd1;
    localparam logic [1:0] PH_IMPACT = 2'd2;

    localparam logic [2:0] REG_LOW_G = 3'd0;
    localparam logic [2:0] REG_DIRECT_IMPACT = 3'd1;
    localparam logic [2:0] REG_IMPACT = 3'd2;
    localparam logic [2:0] REG_EVENT_WINDOW = 3'd3;
    localparam logic [2:0] REG_STILL_TIME = 3'd4;
    localparam logic [2:0] REG_TILT_CHANGE = 3'd5;
    localparam logic [2:0] REG_CANCEL_WINDOW = 3'd6;

    localparam logic [15:0] STILL_ACCEL_LIMIT = 16'd192;
    localparam logic [15:0] STILL_RATE_LIMIT = 16'd307;

    typedef struct packed {
        logic [15:0] low_g_level;
        logic [15:0] direct_impact_level;
        logic [15:0] impact_level;
        logic [15:0] event_window_ms;
        logic [15:0] still_time_ms;
        logic [27:0] tilt_change_sq;
        logic [15:0] cancel_window_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] raw_accel;
        logic [15:0] linear_accel;
        logic [15:0] turn_rate;
        logic signed [14:0] roll_angle;
        logic signed [14:0] pitch_angle;
        logic clear_alert;
    } t_sample;

endpackage
`default_nettype wire

@@ rtl/fd_cfg.sv @@
`default_nettype none
module fd_cfg
    import fd_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire [AddrW-1:0]  paddr,
    input  wire [31:0]       pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [15:0] r_low_g;
    logic [15:0] r_direct;
    logic [15:0] r_impact;
    logic [15:0] r_event;
    logic [15:0] r_still;
    logic [13:0] r_tilt;
    logic [27:0] r_tilt_sq;
    logic [15:0] r_cancel;
    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [27:0] n_tilt_sq;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign wr_idx = paddr[AddrW-1:2];
    assign n_tilt_sq = 28'(pwdata[13:0]) * 28'(pwdata[13:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_g <= 16'd1280;
            r_direct <= 16'd8960;
            r_impact <= 16'd6400;
            r_event <= 16'd1000;
            r_still <= 16'd2000;
            r_tilt <= 14'd2880;
            r_tilt_sq <= 28'd8294400;
            r_cancel <= 16'd10000;
        end else if (wr_en) begin
            case (wr_idx)
                REG_LOW_G: r_low_g <= pwdata[15:0];
                REG_DIRECT_IMPACT: r_direct <= pwdata[15:0];
                REG_IMPACT: r_impact <= pwdata[15:0];
                REG_EVENT_WINDOW: r_event <= pwdata[15:0];
                REG_STILL_TIME: r_still <= pwdata[15:0];
                REG_TILT_CHANGE: begin
                    r_tilt <= pwdata[13:0];
                    r_tilt_sq <= n_tilt_sq;
                end
                REG_CANCEL_WINDOW: r_cancel <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_LOW_G: prdata = {16'd0, r_low_g};
            REG_DIRECT_IMPACT: prdata = {16'd0, r_direct};
            REG_IMPACT: prdata = {16'd0, r_impact};
            REG_EVENT_WINDOW: prdata = {16'd0, r_event};
            REG_STILL_TIME: prdata = {16'd0, r_still};
            REG_TILT_CHANGE: prdata = {18'd0, r_tilt};
            REG_CANCEL_WINDOW: prdata = {16'd0, r_cancel};
            default: prdata = 32'd0;
        endcase
    end

    assign o_cfg.low_g_level = r_low_g;
    assign o_cfg.direct_impact_level = r_direct;
    assign o_cfg.impact_level = r_impact;
    assign o_cfg.event_window_ms = r_event;
    assign o_cfg.still_time_ms = r_still;
    assign o_cfg.tilt_change_sq = r_tilt_sq;
    assign o_cfg.cancel_window_ms = r_cancel;

endmodule
`default_nettype wire

@@ rtl/fd_core.sv @@
`default_nettype none
module fd_core
    import fd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cfg       i_cfg,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_sample    i_sample,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_alert,
    output logic [1:0] o_phase
);

    logic        r_in_vld;
    t_sample     r_in;
    logic        r_out_vld;
    logic        r_out_alert;
    logic [1:0]  r_out_phase;

    logic [1:0]  r_phase;
    logic [31:0] r_phase_start;
    logic [31:0] r_still_start;
    logic        r_still_timing;
    logic        r_alert;
    logic signed [14:0] r_ref_roll;
    logic signed [14:0] r_ref_pitch;
    logic signed [14:0] r_last_roll;
    logic signed [14:0] r_last_pitch;

    logic [1:0]  n_phase;
    logic [31:0] n_phase_start;
    logic [31:0] n_still_start;
    logic        n_still_timing;
    logic        n_alert;
    logic signed [14:0] n_ref_roll;
    logic signed [14:0] n_ref_pitch;
    logic signed [14:0] n_last_roll;
    logic signed [14:0] n_last_pitch;

    logic        advance;
    logic        still;
    logic        latched;
    logic [31:0] elapsed;
    logic [31:0] still_elapsed;
    logic [31:0] start_eff;
    logic signed [15:0] dr;
    logic signed [15:0] dp;
    logic signed [31:0] dr_sq;
    logic signed [31:0] dp_sq;
    logic [31:0] tilt_sq;

    assign advance = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    assign still = (r_in.linear_accel < STILL_ACCEL_LIMIT) &&
                   (r_in.turn_rate < STILL_RATE_LIMIT);
    assign latched = r_alert && !r_in.clear_alert;
    assign elapsed = r_in.time_ms - r_phase_start;
    assign start_eff = r_still_timing ? r_still_start : r_in.time_ms;
    assign still_elapsed = r_in.time_ms - start_eff;
    assign dr = 16'(r_in.roll_angle) - 16'(r_ref_roll);
    assign dp = 16'(r_in.pitch_angle) - 16'(r_ref_pitch);
    assign dr_sq = 32'(dr) * 32'(dr);
    assign dp_sq = 32'(dp) * 32'(dp);
    assign tilt_sq = 32'(dr_sq) + 32'(dp_sq);

    always_comb begin
        n_phase = r_phase;
        n_phase_start = r_phase_start;
        n_still_start = r_still_start;
        n_still_timing = r_still_timing;
        n_alert = latched;
        n_ref_roll = r_ref_roll;
        n_ref_pitch = r_ref_pitch;
        n_last_roll = r_last_roll;
        n_last_pitch = r_last_pitch;
        if (!latched) begin
            n_last_roll = r_in.roll_angle;
            n_last_pitch = r_in.pitch_angle;
            case (r_phase)
                PH_NORMAL: begin
                    if (r_in.raw_accel < i_cfg.low_g_level) begin
                        n_phase = PH_FREEFALL;
                        n_phase_start = r_in.time_ms;
                        n_ref_roll = r_last_roll;
                        n_ref_pitch = r_last_pitch;
                    end else if (r_in.raw_accel > i_cfg.direct_impact_level) begin
                        n_phase = PH_IMPACT;
                        n_phase_start = r_in.time_ms;
                        n_still_timing = 1'b0;
                        n_ref_roll = r_last_roll;
                        n_ref_pitch = r_last_pitch;
                    end
                end
                PH_FREEFALL: begin
                    if (elapsed > {16'd0, i_cfg.event_window_ms}) begin
                        n_phase = PH_NORMAL;
                    end else if (r_in.raw_accel > i_cfg.impact_level) begin
                        n_phase = PH_IMPACT;
                        n_phase_start = r_in.time_ms;
                        n_still_timing = 1'b0;
                    end
                end
                default: begin
                    if (still) begin
                        n_still_start = start_eff;
                        n_still_timing = 1'b1;
                        if (still_elapsed >= {16'd0, i_cfg.still_time_ms} &&
                            tilt_sq >= {4'd0, i_cfg.tilt_change_sq}) begin
                            n_alert = 1'b1;
                            n_phase = PH_NORMAL;
                        end
                    end else begin
                        n_still_timing = 1'b0;
                    end
                    if (elapsed > {16'd0, i_cfg.cancel_window_ms}) begin
                        n_phase = PH_NORMAL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase <= PH_NORMAL;
            r_phase_start <= 32'd0;
            r_still_start <= 32'd0;
            r_still_timing <= 1'b0;
            r_alert <= 1'b0;
            r_ref_roll <= 15'sd0;
            r_ref_pitch <= 15'sd0;
            r_last_roll <= 15'sd0;
            r_last_pitch <= 15'sd0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_phase <= n_phase;
                r_phase_start <= n_phase_start;
                r_still_start <= n_still_start;
                r_still_timing <= n_still_timing;
                r_alert <= n_alert;
                r_ref_roll <= n_ref_roll;
                r_ref_pitch <= n_ref_pitch;
                r_last_roll <= n_last_roll;
                r_last_pitch <= n_last_pitch;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_sample;
        end
        if (advance) begin
            r_out_alert <= n_alert;
            r_out_phase <= n_phase;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_alert = r_out_alert;
    assign o_phase = r_out_phase;

endmodule
`default_nettype wire

@@ rtl/fall_detector_unit.sv @@
// Fall detector on a stream of motion samples.
// Each word on the s_axis side is one sample: tdata carries the timestamp,
// raw and linear acceleration, turn rate, roll and pitch, and tuser carries
// the request to clear a latched alert before the sample is processed.
// Each accepted sample yields exactly one word on the m_axis side with the
// alert latch and the detector phase after that sample.
// A sample is registered on acceptance, and its result is registered in the
// result register once it is empty or its word is taken. One sample per
// cycle is sustained while m_axis_tready is high; the detector state updates
// in the same cycle that the result register loads.
// When m_axis_tready is low the result register holds its word, one more
// sample waits in the input register, and s_axis_tready then drops.
// Thresholds and windows are set over APB; the user must set them only while
// no sample is in flight, which the block does not enforce. Reset restores
// the default register values, returns the phase to normal, clears the alert
// latch and all reference angles, and empties both pipeline registers.
`default_nettype none
module fall_detector_unit
    import fd_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [AddrW-1:0]   paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    // time_ms[31:0], raw_accel[47:32], linear_accel[63:48], turn_rate[79:64],
    // roll_angle[94:80], pitch_angle[109:95], zero fill[111:110]
    input  wire [111:0]       s_axis_tdata,
    // clear_alert[0]
    input  wire               s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    // alert_active[0], phase_code[2:1], zero fill[7:3]
    output logic [7:0]        m_axis_tdata
);

    t_cfg       cfg;
    t_sample    sample;
    logic       alert;
    logic [1:0] phase;

    assign sample.time_ms = s_axis_tdata[31:0];
    assign sample.raw_accel = s_axis_tdata[47:32];
    assign sample.linear_accel = s_axis_tdata[63:48];
    assign sample.turn_rate = s_axis_tdata[79:64];
    assign sample.roll_angle = s_axis_tdata[94:80];
    assign sample.pitch_angle = s_axis_tdata[109:95];
    assign sample.clear_alert = s_axis_tuser;

    fd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_sample    (sample),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_alert     (alert),
        .o_phase     (phase)
    );

    assign m_axis_tdata = {5'd0, phase, alert};

endmodule
`default_nettype wire
